[sv/mm2_pkg.sv]
// ----------------------------------------------------------------------------
// mm2_pkg
// Shared types and constants for the murmur2 string hash core.
// ----------------------------------------------------------------------------
package mm2_pkg;

	localparam int WORD_W  = 32;
	localparam int BYTES_W = 3;
	localparam int ADDR_W  = 1;

	localparam logic [WORD_W-1:0] MIX_MUL    = 32'h5bd1_e995;
	localparam logic [WORD_W-1:0] SEED_RESET = 32'hc70f_6907;
	localparam int                MIX_SHIFT  = 24;
	localparam int                FIN_SHIFT_A = 13;
	localparam int                FIN_SHIFT_B = 15;

	// register byte addresses
	localparam logic [ADDR_W-1:0] REG_SEED = 1'b0;

	// datapath multiplier operation
	typedef enum logic [2:0] {
		OP_NONE,
		OP_KEY1,
		OP_KEY2,
		OP_HASH_FULL,
		OP_HASH_TAIL,
		OP_FINAL
	} mm2_op_t;

	typedef struct packed {
		logic    load;     // capture chunk and starting hash
		logic    tail_xor; // fold masked tail bytes into hash on load
		mm2_op_t op;
	} mm2_cmd_t;

endpackage

[sv/mm2_if.sv]
// ----------------------------------------------------------------------------
// mm2 channel interfaces
// Chunk input channel and hash result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm2_chunk_if;
	logic        valid;
	logic        ready;
	logic [31:0] chunk_word;
	logic [2:0]  chunk_bytes;
	logic        first_chunk;
	logic        last_chunk;
	logic [31:0] message_length;

	modport source (output valid, chunk_word, chunk_bytes, first_chunk, last_chunk,
		message_length, input ready);
	modport sink (input valid, chunk_word, chunk_bytes, first_chunk, last_chunk,
		message_length, output ready);
endinterface

interface mm2_hash_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

[sv/mm2_dp.sv]
// ----------------------------------------------------------------------------
// mm2_dp
// Hash datapath: running hash, key register and one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module mm2_dp
	import mm2_pkg::*;
(
	input  logic              clk,
	input  mm2_cmd_t          cmd,
	input  logic [WORD_W-1:0] seed,
	input  logic [WORD_W-1:0] chunk_word,
	input  logic [BYTES_W-1:0] chunk_bytes,
	input  logic              first_chunk,
	input  logic [WORD_W-1:0] message_length,
	input  logic              arst_n,
	output logic [WORD_W-1:0] hash_value
);

	logic [WORD_W-1:0] h_q;
	logic [WORD_W-1:0] k_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] out_q;

	logic [WORD_W-1:0] h_start;
	logic [WORD_W-1:0] tail_mask;
	logic [WORD_W-1:0] mul_a;
	logic [WORD_W-1:0] mul_p;
	logic [WORD_W-1:0] fin_val;

	assign h_start = first_chunk ? (seed ^ message_length) : h_q;

	always_comb begin
		case (chunk_bytes)
			3'd1:    tail_mask = 32'h0000_00ff;
			3'd2:    tail_mask = 32'h0000_ffff;
			3'd3:    tail_mask = 32'h00ff_ffff;
			default: tail_mask = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.op)
			OP_KEY1:      mul_a = word_q;
			OP_KEY2:      mul_a = k_q ^ (k_q >> MIX_SHIFT);
			OP_HASH_FULL: mul_a = h_q;
			OP_HASH_TAIL: mul_a = h_q;
			OP_FINAL:     mul_a = h_q ^ (h_q >> FIN_SHIFT_A);
			default:      mul_a = '0;
		endcase
	end

	// product modulo 2^32
	assign mul_p   = mul_a * MIX_MUL;
	assign fin_val = mul_p ^ (mul_p >> FIN_SHIFT_B);

	// running hash is control-visible state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (cmd.load) begin
			h_q <= cmd.tail_xor ? (h_start ^ (chunk_word & tail_mask)) : h_start;
		end else if (cmd.op == OP_HASH_FULL) begin
			h_q <= mul_p ^ k_q;
		end else if (cmd.op == OP_HASH_TAIL) begin
			h_q <= mul_p;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= chunk_word;
		end
		if (cmd.op == OP_KEY1 || cmd.op == OP_KEY2) begin
			k_q <= mul_p;
		end
		if (cmd.op == OP_FINAL) begin
			out_q <= fin_val;
		end
	end

	assign hash_value = out_q;

endmodule

[sv/mm2_ctrl.sv]
// ----------------------------------------------------------------------------
// mm2_ctrl
// Sequencer: key mix and hash update or a tail update; last chunks finalize.
// ----------------------------------------------------------------------------
module mm2_ctrl
	import mm2_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTES_W-1:0] chunk_bytes,
	input  logic               last_chunk,
	output logic               out_valid,
	input  logic               out_ready,
	output mm2_cmd_t           cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY1,
		ST_KEY2,
		ST_HASH,
		ST_TAIL,
		ST_FINAL
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   out_valid_q;

	logic accept;
	logic is_tail;
	logic is_empty;
	logic out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_tail  = last_chunk && (chunk_bytes != 3'd0) && (chunk_bytes < 3'd4);
	assign is_empty = last_chunk && (chunk_bytes == 3'd0);
	// result register free now or emptied at this edge
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.load     = accept;
		cmd.tail_xor = accept && is_tail;
		unique case (state_q)
			ST_KEY1:  cmd.op = OP_KEY1;
			ST_KEY2:  cmd.op = OP_KEY2;
			ST_HASH:  cmd.op = OP_HASH_FULL;
			ST_TAIL:  cmd.op = OP_HASH_TAIL;
			ST_FINAL: cmd.op = out_free ? OP_FINAL : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINAL && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_chunk;
						if (is_tail) begin
							state_q <= ST_TAIL;
						end else if (is_empty) begin
							state_q <= ST_FINAL;
						end else begin
							state_q <= ST_KEY1;
						end
					end
				end
				ST_KEY1: state_q <= ST_KEY2;
				ST_KEY2: state_q <= ST_HASH;
				ST_HASH: state_q <= last_q ? ST_FINAL : ST_IDLE;
				ST_TAIL: state_q <= ST_FINAL;
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/murmur2_string_hash_core.sv]
// ----------------------------------------------------------------------------
// murmur2_string_hash_core
// 32-bit MurmurHash2 of a byte message fed as little-endian 32-bit chunks.
// ----------------------------------------------------------------------------
// chunk: valid/ready input; one transfer per 32-bit chunk, first byte in
//   bits 7:0. first_chunk starts a message at seed ^ message_length;
//   last_chunk closes it, and chunk_bytes of one to three marks tail bytes there.
// digest: valid/ready output carrying one hash_value per last chunk.
// apb: seed register at address 0, written in the access phase, readable.
// sequence: every multiply goes through one shared 32x32 multiplier, so a
//   full chunk steps through KEY1, KEY2 and HASH before the next transfer,
//   a tail chunk through TAIL and FINAL, an empty last chunk through FINAL
//   alone and a last full chunk through KEY1, KEY2, HASH and FINAL. The
//   hash turns valid in the same cycle that ready returns.
// stall: the hash sits in an output register; a new chunk is taken while
//   it waits, and only a following finalization holds until it is taken.
// reset: seed returns to its default, running hash clears to zero, no
//   result is pending.
// ----------------------------------------------------------------------------
module murmur2_string_hash_core
	import mm2_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	mm2_chunk_if.sink         chunk,
	mm2_hash_if.source        digest
);

	logic [WORD_W-1:0] seed_q;
	mm2_cmd_t          cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SEED) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite && paddr == REG_SEED) begin
			seed_q <= pwdata;
		end
	end

	mm2_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (chunk.valid),
		.in_ready    (chunk.ready),
		.chunk_bytes (chunk.chunk_bytes),
		.last_chunk  (chunk.last_chunk),
		.out_valid   (digest.valid),
		.out_ready   (digest.ready),
		.cmd         (cmd)
	);

	mm2_dp u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.seed           (seed_q),
		.chunk_word     (chunk.chunk_word),
		.chunk_bytes    (chunk.chunk_bytes),
		.first_chunk    (chunk.first_chunk),
		.message_length (chunk.message_length),
		.arst_n         (arst_n),
		.hash_value     (digest.hash_value)
	);

endmodule

[dv/mm2_digest_checker.sv]
// ----------------------------------------------------------------------------
// mm2_digest_checker
// Watches the seed register writes and both channels of the murmur2 core,
// keeps its own running hash, and compares every digest with the oldest
// predicted hash.
// ----------------------------------------------------------------------------
module mm2_digest_checker
	import mm2_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	mm2_chunk_if              chunk_bus,
	mm2_hash_if               digest_bus,
	output int                mismatches,
	output int                hashes_pending,
	output int                hashes_checked
);

	logic [31:0] seed_model = SEED_RESET;
	logic [31:0] hash_model = '0;
	logic [31:0] predicted_hashes[$];
	logic [31:0] start_hash;
	logic [31:0] oldest_hash;
	int          mismatch_count = 0;
	int          pending_count = 0;
	int          checked_count = 0;

	assign mismatches     = mismatch_count;
	assign hashes_pending = pending_count;
	assign hashes_checked = checked_count;

	// full chunks go through the key mix; a short last chunk folds in its tail bytes
	function automatic logic [31:0] absorb_chunk(input logic [31:0] h,
		input logic [31:0] word, input logic [2:0] nbytes, input logic is_last);
		logic [31:0] k;
		logic [31:0] keep;
		if (!is_last || nbytes >= 3'd4) begin
			k = word * MIX_MUL;
			k = k ^ (k >> MIX_SHIFT);
			k = k * MIX_MUL;
			return (h * MIX_MUL) ^ k;
		end
		if (nbytes == 3'd0)
			return h;
		keep = (32'd1 << (8 * nbytes)) - 32'd1;
		return (h ^ (word & keep)) * MIX_MUL;
	endfunction

	function automatic logic [31:0] finalize_hash(input logic [31:0] h);
		logic [31:0] f;
		f = h ^ (h >> FIN_SHIFT_A);
		f = f * MIX_MUL;
		return f ^ (f >> FIN_SHIFT_B);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_model = SEED_RESET;
			hash_model = '0;
			predicted_hashes.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_SEED)
				seed_model = pwdata;
			if (chunk_bus.valid && chunk_bus.ready) begin
				start_hash = chunk_bus.first_chunk ?
					(seed_model ^ chunk_bus.message_length) : hash_model;
				hash_model = absorb_chunk(start_hash, chunk_bus.chunk_word,
					chunk_bus.chunk_bytes, chunk_bus.last_chunk);
				if (chunk_bus.last_chunk)
					predicted_hashes.push_back(finalize_hash(hash_model));
			end
			if (digest_bus.valid && digest_bus.ready) begin
				checked_count++;
				if (predicted_hashes.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected digest %08h", $time, digest_bus.hash_value);
				end else begin
					oldest_hash = predicted_hashes.pop_front();
					if (digest_bus.hash_value !== oldest_hash) begin
						mismatch_count++;
						$display("%0t: hash_value mismatch, expected %08h, actual %08h",
							$time, oldest_hash, digest_bus.hash_value);
					end
				end
			end
		end
		pending_count = predicted_hashes.size();
	end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives chunk messages and seed writes into the murmur2 string hash core,
// with bursty input and a stalling digest receiver; the checker predicts
// and compares every hash.
// ----------------------------------------------------------------------------
module testbench;
	import mm2_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 16;

	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_QUARTER,
		RDY_LONG_STALL
	} ready_style_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int mismatches;
	int hashes_pending;
	int hashes_checked;

	int burst_left = 1;
	int chunks_sent = 0;
	int messages_sent = 0;
	int seed_writes = 0;
	int idle_cycles = 0;

	ready_style_t ready_style = RDY_ALWAYS;
	int           style_cycles = 0;
	int           stall_left = 0;

	mm2_chunk_if chunk_bus();
	mm2_hash_if  digest_bus();

	murmur2_string_hash_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.chunk   (chunk_bus),
		.digest  (digest_bus)
	);

	mm2_digest_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.chunk_bus      (chunk_bus),
		.digest_bus     (digest_bus),
		.mismatches     (mismatches),
		.hashes_pending (hashes_pending),
		.hashes_checked (hashes_checked)
	);

	always #6 clk = ~clk;

	// digest receiver switches between randomly picked stall styles
	always @(negedge clk) begin
		if (style_cycles == 0) begin
			ready_style  = ready_style_t'($urandom_range(0, 3));
			style_cycles = $urandom_range(20, 120);
		end
		style_cycles--;
		case (ready_style)
			RDY_ALWAYS: begin
				digest_bus.ready <= 1'b1;
			end
			RDY_COIN: begin
				digest_bus.ready <= 1'($urandom_range(0, 1));
			end
			RDY_QUARTER: begin
				digest_bus.ready <= (style_cycles % 4 == 0);
			end
			default: begin
				if (stall_left > 0) begin
					digest_bus.ready <= 1'b0;
					stall_left--;
				end else begin
					digest_bus.ready <= 1'b1;
					stall_left = $urandom_range(2, 15);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if ((chunk_bus.valid && chunk_bus.ready) || (digest_bus.valid && digest_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("testbench: errors");
			$finish;
		end
	end

	// entered and left just after a falling edge
	task automatic send_chunk(input logic [31:0] word, input logic [2:0] nbytes,
		input logic start_msg, input logic end_msg, input logic [31:0] msg_len);
		int gap;
		chunk_bus.valid          <= 1'b1;
		chunk_bus.chunk_word     <= word;
		chunk_bus.chunk_bytes    <= nbytes;
		chunk_bus.first_chunk    <= start_msg;
		chunk_bus.last_chunk     <= end_msg;
		chunk_bus.message_length <= msg_len;
		@(posedge clk);
		while (!chunk_bus.ready)
			@(posedge clk);
		chunks_sent++;
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			chunk_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) :
				$urandom_range(1, 12);
		end
	endtask

	// hold off the sender until every hash has come out and the core has settled
	task automatic drain;
		chunk_bus.valid <= 1'b0;
		while (hashes_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_SEED;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		seed_writes++;
	endtask

	task automatic send_message;
		int          total;
		int          nchunks;
		logic [2:0]  tail_bytes;
		logic [2:0]  nb;
		logic [31:0] len_field;
		total = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
		nchunks = (total + 3) / 4;
		if (nchunks == 0)
			nchunks = 1;
		if (total == 0)
			tail_bytes = 3'd0;
		else if (total % 4 == 0)
			tail_bytes = 3'd4;
		else
			tail_bytes = 3'(total % 4);
		// length is only folded into the start value, so a wrong one is fair game
		len_field = ($urandom_range(0, 7) == 0) ? $urandom() : total;
		for (int i = 0; i < nchunks; i++) begin
			if (i == nchunks - 1)
				nb = tail_bytes;
			else
				nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
			send_chunk($urandom(), nb, i == 0, i == nchunks - 1, len_field);
		end
		messages_sent++;
	endtask

	task automatic send_noise;
		repeat ($urandom_range(1, 3))
			send_chunk($urandom(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom());
	endtask

	task automatic random_phase(input logic [31:0] seed, input int chunk_goal);
		int goal;
		drain();
		write_seed(seed);
		goal = chunks_sent + chunk_goal;
		while (chunks_sent < goal) begin
			if ($urandom_range(0, 6) == 0)
				send_noise();
			else
				send_message();
			if ($urandom_range(0, 15) == 0)
				drain();
		end
	endtask

	initial begin
		chunk_bus.valid          = 1'b0;
		chunk_bus.chunk_word     = '0;
		chunk_bus.chunk_bytes    = '0;
		chunk_bus.first_chunk    = 1'b0;
		chunk_bus.last_chunk     = 1'b0;
		chunk_bus.message_length = '0;
		digest_bus.ready         = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default seed: chunks with no opening chunk start from the cleared hash
		send_chunk(32'h0123_4567, 3'd4, 1'b0, 1'b0, 32'd0);
		send_chunk(32'hffff_ffff, 3'd2, 1'b0, 1'b1, 32'd0);
		// keeps going from the unfinalized hash the last chunk left
		send_chunk(32'h89ab_cdef, 3'd4, 1'b0, 1'b1, 32'hffff_ffff);
		// single-chunk messages over every byte count
		for (int nb = 0; nb < 8; nb++)
			send_chunk((nb % 2) ? 32'hffff_ffff : 32'h0000_0000, 3'(nb), 1'b1, 1'b1,
				(nb < 4) ? 32'(nb) : 32'hffff_ffff);
		send_chunk(32'hdead_beef, 3'd0, 1'b1, 1'b1, 32'd0);
		// byte counts on inner chunks do not matter
		send_chunk(32'h6867_6665, 3'd1, 1'b1, 1'b0, 32'd11);
		send_chunk(32'h6c6b_6a69, 3'd7, 1'b0, 1'b0, 32'hffff_ffff);
		send_chunk(32'hff6f_6e6d, 3'd3, 1'b0, 1'b1, 32'd0);
		send_chunk(32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h8000_0000);
		send_chunk(32'hffff_ffff, 3'd4, 1'b0, 1'b1, 32'h0000_0001);

		random_phase(32'h0000_0000, 100);
		random_phase(32'hffff_ffff, 100);
		random_phase($urandom(), 100);
		random_phase($urandom(), 100);

		drain();
		$display("run: %0d chunks, %0d messages, %0d hashes checked", chunks_sent,
			messages_sent, hashes_checked);
		$display("run: %0d seed writes beside the reset seed, with full and short tails",
			seed_writes);
		if (mismatches == 0 && hashes_pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
